FILE: sv/mwuf_pkg.sv
// mwuf_pkg: shared widths, reset values and result type for the maze wall union-find engine
// no dependencies; imported by the channel interfaces and every module of the block
package mwuf_pkg;

  localparam int CELL_W        = 10;    // cell index field width
  localparam int CFG_W         = 11;    // cells_in_use register width
  localparam int CNT_W         = 10;    // merge counter width
  localparam int MAX_CELLS_DEF = 1024;  // default parent table depth
  localparam int QUEUE_DEPTH   = 2;     // front-to-back queue entries

  localparam logic [CFG_W-1:0] CELLS_RESET = CFG_W'(1024);
  localparam logic [CNT_W-1:0] CNT_MAX     = '1;

  // one result beat
  typedef struct packed {
    logic              wall_removed;
    logic [CELL_W-1:0] merged_root;
    logic              maze_done;
  } mwuf_res_t;

endpackage

FILE: sv/mwuf_if.sv
// mwuf_if: valid/ready channel interfaces for wall beats, result beats and the config write
// depends on mwuf_pkg for field widths

interface mwuf_in_if import mwuf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_first;
  logic [CELL_W-1:0] cell_second;

  modport source (output valid, output cell_first, output cell_second, input ready);
  modport sink   (input valid, input cell_first, input cell_second, output ready);
endinterface

interface mwuf_out_if import mwuf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              wall_removed;
  logic [CELL_W-1:0] merged_root;
  logic              maze_done;

  modport source (output valid, output wall_removed, output merged_root, output maze_done,
                  input ready);
  modport sink   (input valid, input wall_removed, input merged_root, input maze_done,
                  output ready);
endinterface

interface mwuf_cfg_if import mwuf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] cells_in_use;

  modport source (output valid, output cells_in_use, input ready);
  modport sink   (input valid, input cells_in_use, output ready);
endinterface

FILE: sv/mwuf_front.sv
// mwuf_front: takes wall beats, folds cell indices into the table range, feeds the queue
// depends on mwuf_pkg
module mwuf_front import mwuf_pkg::*; #(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  parameter int PW        = $clog2(MAX_CELLS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              enable,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CELL_W-1:0] in_first,
  input  logic [CELL_W-1:0] in_second,
  output logic              push,
  input  logic              q_ready,
  output logic [PW-1:0]     q_first,
  output logic [PW-1:0]     q_second
);

  localparam int RW = (PW > CELL_W) ? PW : CELL_W;
  localparam logic [RW:0] MAXV = (RW+1)'(MAX_CELLS);

  logic              hold_r, hold_nxt;
  logic [CELL_W-1:0] a_r, a_nxt;
  logic [CELL_W-1:0] b_r, b_nxt;
  logic              a_big, b_big;
  logic              accept;

  // index wraps modulo table depth, one subtract per cycle
  assign a_big    = (RW+1)'(a_r) >= MAXV;
  assign b_big    = (RW+1)'(b_r) >= MAXV;
  assign push     = hold_r && !a_big && !b_big && q_ready;
  assign in_ready = enable && (!hold_r || push);
  assign accept   = in_valid && in_ready;
  assign q_first  = PW'(a_r);
  assign q_second = PW'(b_r);

  always_comb begin
    hold_nxt = hold_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (accept) begin
      hold_nxt = 1'b1;
      a_nxt    = in_first;
      b_nxt    = in_second;
    end else if (push) begin
      hold_nxt = 1'b0;
    end else if (hold_r) begin
      if (a_big) begin
        a_nxt = a_r - CELL_W'(MAX_CELLS);
      end
      if (b_big) begin
        b_nxt = b_r - CELL_W'(MAX_CELLS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

endmodule

FILE: sv/mwuf_queue.sv
// mwuf_queue: short fifo of folded cell pairs between front and back
// depends on mwuf_pkg
module mwuf_queue import mwuf_pkg::*; #(
  parameter int W = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  slot_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = count_r < CW'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/mwuf_back.sv
// mwuf_back: parent table, root walks, linking, merge count and result register
// depends on mwuf_pkg
module mwuf_back import mwuf_pkg::*; #(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  parameter int PW        = $clog2(MAX_CELLS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] target,
  output logic             clearing,
  input  logic             q_valid,
  input  logic [PW-1:0]    q_first,
  input  logic [PW-1:0]    q_second,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output mwuf_res_t        out_res
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_WALK_A = 5'b00100,
    ST_WALK_B = 5'b01000,
    ST_RESULT = 5'b10000
  } state_t;

  // entry: root flag on top, parent index below
  logic [PW:0]      mem [MAX_CELLS];
  logic [PW:0]      rd_data_r;
  logic [PW-1:0]    rd_addr;
  logic             we;
  logic [PW-1:0]    wa;
  logic [PW:0]      wd;

  state_t           state_r, state_nxt;
  logic [PW-1:0]    clr_idx_r, clr_idx_nxt;
  logic [PW-1:0]    cur_r, cur_nxt;
  logic [PW-1:0]    b_hold_r, b_hold_nxt;
  logic [PW-1:0]    root_a_r, root_a_nxt;
  logic [CNT_W-1:0] merge_count_r, merge_count_nxt;
  mwuf_res_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  mwuf_res_t        out_res_r, out_res_nxt;
  logic             is_root;
  logic [PW-1:0]    parent;

  assign is_root   = rd_data_r[PW];
  assign parent    = rd_data_r[PW-1:0];
  assign clearing  = state_r == ST_CLEAR;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    state_nxt       = state_r;
    clr_idx_nxt     = clr_idx_r;
    cur_nxt         = cur_r;
    b_hold_nxt      = b_hold_r;
    root_a_nxt      = root_a_r;
    merge_count_nxt = merge_count_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r;
    out_res_nxt     = out_res_r;
    rd_addr         = cur_r;
    we              = 1'b0;
    wa              = clr_idx_r;
    wd              = {1'b1, {PW{1'b0}}};
    q_pop           = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        if (clr_idx_r == PW'(MAX_CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        rd_addr = q_first;
        if (q_valid) begin
          q_pop = 1'b1;
          if (merge_count_r >= target) begin
            res_nxt   = '{wall_removed: 1'b0, merged_root: '0, maze_done: 1'b1};
            state_nxt = ST_RESULT;
          end else begin
            cur_nxt    = q_first;
            b_hold_nxt = q_second;
            state_nxt  = ST_WALK_A;
          end
        end
      end
      ST_WALK_A: begin
        if (is_root) begin
          root_a_nxt = cur_r;
          cur_nxt    = b_hold_r;
          rd_addr    = b_hold_r;
          state_nxt  = ST_WALK_B;
        end else begin
          cur_nxt = parent;
          rd_addr = parent;
        end
      end
      ST_WALK_B: begin
        if (is_root) begin
          if (root_a_r != cur_r) begin
            we = 1'b1;
            wa = root_a_r;
            wd = {1'b0, cur_r};
            if (merge_count_r != CNT_MAX) begin
              merge_count_nxt = merge_count_r + 1'b1;
            end
          end
          res_nxt.wall_removed = root_a_r != cur_r;
          res_nxt.merged_root  = CELL_W'(cur_r);
          res_nxt.maze_done    = merge_count_nxt >= target;
          state_nxt            = ST_RESULT;
        end else begin
          cur_nxt = parent;
          rd_addr = parent;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt   = ST_CLEAR;
        clr_idx_nxt = '0;
      end
    endcase
  end

  // parent table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_idx_r     <= '0;
      merge_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_idx_r     <= clr_idx_nxt;
      merge_count_r <= merge_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    cur_r     <= cur_nxt;
    b_hold_r  <= b_hold_nxt;
    root_a_r  <= root_a_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

FILE: sv/maze_wall_union_find.sv
// maze_wall_union_find: top level of the disjoint-set engine for kruskal maze carving
// depends on mwuf_pkg, mwuf_if, mwuf_front, mwuf_queue and mwuf_back
//
//   channel  dir  beat contents                          handshake
//   in_ch    in   cell_first, cell_second (10b each)     valid/ready
//   out_ch   out  wall_removed, merged_root, maze_done   valid/ready
//   cfg_ch   in   cells_in_use (11b)                     valid/ready, ready always high
//
// one wall beat at a time in the back end: a pop in idle, then walk steps that follow the
// parent links of each cell up to its root, then a result step that waits for the output
// register; the walks are serialised by the single read port of the parent table
// after reset the parent table is swept to all roots; no input beats are taken
// meanwhile (config writes still are)
// a waiting result sits in the output register while the front keeps filling the queue
module maze_wall_union_find import mwuf_pkg::*; #(
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mwuf_in_if.sink    in_ch,
  mwuf_out_if.source out_ch,
  mwuf_cfg_if.sink   cfg_ch
);

  localparam int PW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  // top cell count the merge target can reach
  localparam int CAP = (MAX_CELLS < 1024) ? MAX_CELLS : 1024;

  logic [CFG_W-1:0] cells_in_use_r, cells_in_use_nxt;
  logic [CFG_W-1:0] cells_clamped;
  logic [CNT_W-1:0] target;

  logic             clearing;
  logic             push, q_ready;
  logic [PW-1:0]    f_first, f_second;
  logic             q_pop, q_valid;
  logic [2*PW-1:0]  q_data;
  mwuf_res_t        res;

  // config register, always ready
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cells_in_use_nxt = cells_in_use_r;
    if (cfg_ch.valid) begin
      cells_in_use_nxt = cfg_ch.cells_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_in_use_r <= CELLS_RESET;
    end else begin
      cells_in_use_r <= cells_in_use_nxt;
    end
  end

  // zero counts as one cell, anything past the table saturates
  always_comb begin
    cells_clamped = cells_in_use_r;
    if (cells_in_use_r == '0) begin
      cells_clamped = CFG_W'(1);
    end else if (cells_in_use_r > CFG_W'(CAP)) begin
      cells_clamped = CFG_W'(CAP);
    end
  end

  // merges needed to finish: cells minus one
  assign target = CNT_W'(cells_clamped - 1'b1);

  mwuf_front #(
    .MAX_CELLS (MAX_CELLS),
    .PW        (PW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (!clearing),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_first  (in_ch.cell_first),
    .in_second (in_ch.cell_second),
    .push      (push),
    .q_ready   (q_ready),
    .q_first   (f_first),
    .q_second  (f_second)
  );

  mwuf_queue #(
    .W (2*PW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (q_ready),
    .push_data  ({f_first, f_second}),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  mwuf_back #(
    .MAX_CELLS (MAX_CELLS),
    .PW        (PW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .target    (target),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_first   (q_data[2*PW-1:PW]),
    .q_second  (q_data[PW-1:0]),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.wall_removed = res.wall_removed;
  assign out_ch.merged_root  = res.merged_root;
  assign out_ch.maze_done    = res.maze_done;

endmodule
